/* src/dphh_pkg.sv */
// shared types, constants and register codes for the straight-line drive controller
// no dependencies; every other file depends on this package
`default_nettype none

package dphh_pkg;

    // sizes fixed by the item and register formats
    localparam int POSITION_BITS  = 21;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int WHEEL_COUNT    = 6;
    localparam int TGT_W          = 20;
    localparam int GAIN_W         = 16;
    localparam int MAXP_W         = 7;
    localparam int HEAD_W         = 17;
    localparam int HSUM_W         = 32;
    localparam int CMD_W          = 8;
    localparam int CMD_LIMIT      = 127;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 20;

    // sum of absolute positions and the divide by wheel count
    localparam int SUM_W = POSITION_BITS + 3;
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / WHEEL_COUNT);
    localparam int CMP_W = (SUM_W > TGT_W + 3) ? SUM_W : TGT_W + 3;

    // distance error path
    localparam int E_W  = TGT_W + 1;
    localparam int D_W  = TGT_W + 2;
    localparam int EP_W = E_W + GAIN_W + 1;
    localparam int DP_W = D_W + GAIN_W + 1;
    localparam int PS_W = DP_W + 1;
    localparam int P_W  = PS_W - GAIN_FRAC_BITS;

    // heading path
    localparam int HD_W  = HEAD_W + 1;
    localparam int HP_W  = HEAD_W + GAIN_W + 1;
    localparam int HDP_W = HD_W + GAIN_W + 1;
    localparam int SP_W  = HSUM_W + GAIN_W + 1;
    localparam int TS_W  = SP_W + 2;
    localparam int T_W   = TS_W - GAIN_FRAC_BITS;

    localparam int MIX_W = ((P_W > T_W) ? P_W : T_W) + 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_DISTANCE = 3'd0,
        REG_DISTANCE_KP     = 3'd1,
        REG_DISTANCE_KD     = 3'd2,
        REG_MAX_POWER       = 3'd3,
        REG_HEADING_KP      = 3'd4,
        REG_HEADING_KI      = 3'd5,
        REG_HEADING_KD      = 3'd6,
        REG_REVERSE         = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_TICK  = 1'b1
    } action_t;

    typedef struct packed {
        logic [TGT_W-1:0]  target_distance;
        logic [GAIN_W-1:0] distance_kp;
        logic [GAIN_W-1:0] distance_kd;
        logic [MAXP_W-1:0] max_power;
        logic [GAIN_W-1:0] heading_kp;
        logic [GAIN_W-1:0] heading_ki;
        logic [GAIN_W-1:0] heading_kd;
        logic              reverse;
    } cfg_t;

    typedef struct packed {
        logic                                      action;
        logic [WHEEL_COUNT-1:0][POSITION_BITS-1:0] pos;
        logic [HEAD_W-1:0]                         heading;
    } item_t;

    typedef struct packed {
        logic              action;
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  q_est;
        logic [HEAD_W-1:0] heading;
    } front_t;

    typedef struct packed {
        logic              zero;
        logic              fin;
        logic [EP_W-1:0]   ep;
        logic [DP_W-1:0]   dp;
        logic [HP_W-1:0]   hp;
        logic [SP_W-1:0]   sp;
        logic [HDP_W-1:0]  hdp;
    } prod_t;

    typedef struct packed {
        logic [WHEEL_COUNT-1:0][CMD_W-1:0] cmd;
        logic                              fin;
    } res_t;

endpackage

`default_nettype wire

/* src/dphh_in_if.sv */
// input channel: action, six encoder positions and heading with valid/ready
// depends on dphh_pkg for field widths
`default_nettype none

interface dphh_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      action;
    logic signed [dphh_pkg::POSITION_BITS-1:0] pos_front_left;
    logic signed [dphh_pkg::POSITION_BITS-1:0] pos_back_left;
    logic signed [dphh_pkg::POSITION_BITS-1:0] pos_middle_left;
    logic signed [dphh_pkg::POSITION_BITS-1:0] pos_front_right;
    logic signed [dphh_pkg::POSITION_BITS-1:0] pos_back_right;
    logic signed [dphh_pkg::POSITION_BITS-1:0] pos_middle_right;
    logic signed [dphh_pkg::HEAD_W-1:0]        heading;

    modport source (
        output valid, action, pos_front_left, pos_back_left, pos_middle_left,
               pos_front_right, pos_back_right, pos_middle_right, heading,
        input  ready
    );

    modport sink (
        input  valid, action, pos_front_left, pos_back_left, pos_middle_left,
               pos_front_right, pos_back_right, pos_middle_right, heading,
        output ready
    );
endinterface

`default_nettype wire

/* src/dphh_out_if.sv */
// result channel: six motor commands and finished flag with valid/ready
// depends on dphh_pkg for field widths
`default_nettype none

interface dphh_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [dphh_pkg::CMD_W-1:0] cmd_front_left;
    logic signed [dphh_pkg::CMD_W-1:0] cmd_back_left;
    logic signed [dphh_pkg::CMD_W-1:0] cmd_middle_left;
    logic signed [dphh_pkg::CMD_W-1:0] cmd_front_right;
    logic signed [dphh_pkg::CMD_W-1:0] cmd_back_right;
    logic signed [dphh_pkg::CMD_W-1:0] cmd_middle_right;
    logic                              finished;

    modport source (
        output valid, cmd_front_left, cmd_back_left, cmd_middle_left,
               cmd_front_right, cmd_back_right, cmd_middle_right, finished,
        input  ready
    );

    modport sink (
        input  valid, cmd_front_left, cmd_back_left, cmd_middle_left,
               cmd_front_right, cmd_back_right, cmd_middle_right, finished,
        output ready
    );
endinterface

`default_nettype wire

/* src/dphh_front.sv */
// front stage: sum of absolute encoder positions and quotient estimate by wheel count
// depends on dphh_pkg
`default_nettype none

module dphh_front (
    input  dphh_pkg::item_t  item_in,
    output dphh_pkg::front_t front_out
);
    import dphh_pkg::*;

    logic [WHEEL_COUNT-1:0][POSITION_BITS-1:0] mag;
    logic [SUM_W-1:0]                          sum;
    logic [2*SUM_W-1:0]                        prod;

    always_comb
    begin
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            // the most negative value maps to its unsigned magnitude
            mag[w] = item_in.pos[w][POSITION_BITS-1] ? (~item_in.pos[w] + 1'b1)
                                                     : item_in.pos[w];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            sum = sum + SUM_W'(mag[w]);
        end
    end

    // floor reciprocal: estimate is the true quotient or one below it
    assign prod = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP);

    assign front_out.action  = item_in.action;
    assign front_out.sum     = sum;
    assign front_out.q_est   = prod[2*SUM_W-1:SUM_W];
    assign front_out.heading = item_in.heading;

endmodule

`default_nettype wire

/* src/dphh_ctrl.sv */
// control stage: finish test, distance and heading errors, history, gain products
// depends on dphh_pkg; holds the controller history registers
`default_nettype none

module dphh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  dphh_pkg::front_t front_in,
    input  dphh_pkg::cfg_t   cfg,
    output dphh_pkg::prod_t  prod_out
);
    import dphh_pkg::*;

    logic signed [E_W-1:0]    prev_e_reg;
    logic signed [E_W-1:0]    prev_e_next;
    logic signed [HSUM_W-1:0] hsum_reg;
    logic signed [HSUM_W-1:0] hsum_next;
    logic signed [HEAD_W-1:0] prev_h_reg;
    logic signed [HEAD_W-1:0] prev_h_next;
    logic                     done_reg;
    logic                     done_next;

    logic [SUM_W-1:0]         q_est6;
    logic [SUM_W-1:0]         rem;
    logic [SUM_W-1:0]         q;
    logic [CMP_W-1:0]         tgt6;
    logic                     over;
    logic                     fin;
    logic                     is_start;
    logic [CMP_W-1:0]         e_full;
    logic signed [E_W-1:0]    e;
    logic signed [D_W-1:0]    d;
    logic signed [HEAD_W-1:0] h;
    logic signed [HSUM_W:0]   hsum_wide;
    logic signed [HSUM_W-1:0] hsum_new;
    logic signed [HD_W-1:0]   hd;
    logic signed [GAIN_W:0]   dkp_s;
    logic signed [GAIN_W:0]   dkd_s;
    logic signed [GAIN_W:0]   hkp_s;
    logic signed [GAIN_W:0]   hki_s;
    logic signed [GAIN_W:0]   hkd_s;

    // correct the quotient estimate with one compare and add
    assign q_est6 = (front_in.q_est << 2) + (front_in.q_est << 1);
    assign rem    = front_in.sum - q_est6;
    assign q      = front_in.q_est + SUM_W'(rem >= SUM_W'(WHEEL_COUNT));

    // exact average test: sum against target times wheel count
    assign tgt6     = CMP_W'(cfg.target_distance) * CMP_W'(WHEEL_COUNT);
    assign over     = CMP_W'(front_in.sum) > tgt6;
    assign fin      = done_reg || over;
    assign is_start = (action_t'(front_in.action) == ACT_START);

    // not finished means quotient <= target, so the error is non-negative
    assign e_full = CMP_W'(cfg.target_distance) - CMP_W'(q);
    assign e      = e_full[E_W-1:0];
    assign d      = D_W'(e) - D_W'(prev_e_reg);

    assign h         = front_in.heading;
    assign hsum_wide = (HSUM_W+1)'(hsum_reg) + (HSUM_W+1)'(h);
    always_comb
    begin
        if (hsum_wide[HSUM_W] != hsum_wide[HSUM_W-1])
        begin
            hsum_new = hsum_wide[HSUM_W] ? {1'b1, {(HSUM_W-1){1'b0}}}
                                         : {1'b0, {(HSUM_W-1){1'b1}}};
        end
        else
        begin
            hsum_new = hsum_wide[HSUM_W-1:0];
        end
    end
    assign hd = HD_W'(h) - HD_W'(prev_h_reg);

    assign dkp_s = {1'b0, cfg.distance_kp};
    assign dkd_s = {1'b0, cfg.distance_kd};
    assign hkp_s = {1'b0, cfg.heading_kp};
    assign hki_s = {1'b0, cfg.heading_ki};
    assign hkd_s = {1'b0, cfg.heading_kd};

    assign prod_out.zero = is_start || fin;
    assign prod_out.fin  = !is_start && fin;
    assign prod_out.ep   = EP_W'(e) * EP_W'(dkp_s);
    assign prod_out.dp   = DP_W'(d) * DP_W'(dkd_s);
    assign prod_out.hp   = HP_W'(h) * HP_W'(hkp_s);
    assign prod_out.sp   = SP_W'(hsum_new) * SP_W'(hki_s);
    assign prod_out.hdp  = HDP_W'(hd) * HDP_W'(hkd_s);

    always_comb
    begin
        prev_e_next = prev_e_reg;
        hsum_next   = hsum_reg;
        prev_h_next = prev_h_reg;
        done_next   = done_reg;
        if (fire)
        begin
            if (is_start)
            begin
                prev_e_next = '0;
                hsum_next   = '0;
                prev_h_next = '0;
                done_next   = 1'b0;
            end
            else if (fin)
            begin
                done_next = 1'b1;
            end
            else
            begin
                prev_e_next = e;
                hsum_next   = hsum_new;
                prev_h_next = h;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_e_reg <= '0;
            hsum_reg   <= '0;
            prev_h_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            prev_e_reg <= prev_e_next;
            hsum_reg   <= hsum_next;
            prev_h_reg <= prev_h_next;
            done_reg   <= done_next;
        end
    end

endmodule

`default_nettype wire

/* src/dphh_mix.sv */
// mix stage: drive power with clamp and reverse, turn power, six saturated commands
// depends on dphh_pkg
`default_nettype none

module dphh_mix (
    input  dphh_pkg::prod_t prod_in,
    input  dphh_pkg::cfg_t  cfg,
    output dphh_pkg::res_t  res_out
);
    import dphh_pkg::*;

    logic signed [PS_W-1:0]  p_sum;
    logic signed [P_W-1:0]   p;
    logic signed [P_W-1:0]   maxp_s;
    logic signed [P_W-1:0]   p_c;
    logic signed [MIX_W-1:0] p_m;
    logic signed [TS_W-1:0]  t_sum;
    logic signed [T_W-1:0]   t;
    logic signed [MIX_W-1:0] turn;
    logic signed [MIX_W-1:0] pos_turn;
    logic signed [MIX_W-1:0] neg_turn;
    logic signed [MIX_W-1:0] neg_p_pos_turn;
    logic signed [MIX_W-1:0] p_neg_turn;

    function automatic logic [CMD_W-1:0] sat_cmd(input logic signed [MIX_W-1:0] v);
        logic [CMD_W-1:0] r;
        if (v > MIX_W'(CMD_LIMIT))
        begin
            r = CMD_W'(CMD_LIMIT);
        end
        else if (v < -MIX_W'(CMD_LIMIT))
        begin
            r = CMD_W'(-CMD_LIMIT);
        end
        else
        begin
            r = v[CMD_W-1:0];
        end
        return r;
    endfunction

    // floor division by 2^frac is the arithmetic shift, taken as a part-select
    assign p_sum  = PS_W'($signed(prod_in.ep)) + PS_W'($signed(prod_in.dp));
    assign p      = p_sum[PS_W-1:GAIN_FRAC_BITS];
    assign maxp_s = P_W'($signed({1'b0, cfg.max_power}));
    assign p_c    = (p > maxp_s) ? maxp_s : p;
    assign p_m    = cfg.reverse ? -MIX_W'(p_c) : MIX_W'(p_c);

    assign t_sum = TS_W'($signed(prod_in.hp)) + TS_W'($signed(prod_in.sp))
                 + TS_W'($signed(prod_in.hdp));
    assign t     = t_sum[TS_W-1:GAIN_FRAC_BITS];
    assign turn  = -MIX_W'(t);

    assign pos_turn       = p_m + turn;
    assign neg_turn       = -p_m - turn;
    assign neg_p_pos_turn = -p_m + turn;
    assign p_neg_turn     = p_m - turn;

    always_comb
    begin
        if (prod_in.zero)
        begin
            res_out.cmd = '0;
        end
        else
        begin
            res_out.cmd[0] = sat_cmd(pos_turn);
            res_out.cmd[1] = sat_cmd(pos_turn);
            res_out.cmd[2] = sat_cmd(neg_turn);
            res_out.cmd[3] = sat_cmd(neg_p_pos_turn);
            res_out.cmd[4] = sat_cmd(neg_p_pos_turn);
            res_out.cmd[5] = sat_cmd(p_neg_turn);
        end
        res_out.fin = prod_in.fin;
    end

endmodule

`default_nettype wire

/* src/drive_pd_with_heading_hold.sv */
// top level of the straight-line drive controller: config registers and pipeline
// depends on dphh_pkg, dphh_in_if, dphh_out_if, dphh_front, dphh_ctrl, dphh_mix
//
//   port      kind          contents
//   item      valid/ready   action, six encoder positions, heading
//   result    valid/ready   six motor commands, finished
//   cfg_*     write only    eight registers by index, no read-back
//
// four register stages: input, sum and quotient estimate, gain products, result.
// one item per cycle unless a result is held; each item passes the stages in that order.
// each stage advances when empty or when the stage after it advances, so a held
// result does not block items behind it until every stage is full.
// reset empties the pipeline, clears the history and loads the register defaults.
`default_nettype none

module drive_pd_with_heading_hold (
    input  logic                             clk,
    input  logic                             rst_n,
    dphh_in_if.sink                          item,
    dphh_out_if.source                       result,
    input  logic                             cfg_we,
    input  logic [dphh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dphh_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dphh_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;

    item_t  in_item;
    item_t  i_reg;
    front_t front_c;
    front_t a_reg;
    prod_t  prod_c;
    prod_t  b_reg;
    res_t   res_c;
    res_t   res_reg;

    logic   i_v_reg;
    logic   a_v_reg;
    logic   b_v_reg;
    logic   res_v_reg;

    logic   res_free;
    logic   b_adv;
    logic   a_adv;
    logic   i_adv;
    logic   fire;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_TARGET_DISTANCE: cfg_next.target_distance = cfg_data[TGT_W-1:0];
                REG_DISTANCE_KP:     cfg_next.distance_kp     = cfg_data[GAIN_W-1:0];
                REG_DISTANCE_KD:     cfg_next.distance_kd     = cfg_data[GAIN_W-1:0];
                REG_MAX_POWER:       cfg_next.max_power       = cfg_data[MAXP_W-1:0];
                REG_HEADING_KP:      cfg_next.heading_kp      = cfg_data[GAIN_W-1:0];
                REG_HEADING_KI:      cfg_next.heading_ki      = cfg_data[GAIN_W-1:0];
                REG_HEADING_KD:      cfg_next.heading_kd      = cfg_data[GAIN_W-1:0];
                REG_REVERSE:         cfg_next.reverse         = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_distance <= '0;
            cfg_reg.distance_kp     <= GAIN_W'(256);
            cfg_reg.distance_kd     <= '0;
            cfg_reg.max_power       <= MAXP_W'(CMD_LIMIT);
            cfg_reg.heading_kp      <= GAIN_W'(1024);
            cfg_reg.heading_ki      <= '0;
            cfg_reg.heading_kd      <= GAIN_W'(256);
            cfg_reg.reverse         <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // stage flow control
    assign res_free   = !res_v_reg || result.ready;
    assign b_adv      = !b_v_reg || res_free;
    assign a_adv      = !a_v_reg || b_adv;
    assign i_adv      = !i_v_reg || a_adv;
    assign item.ready = i_adv;
    assign fire       = b_adv && a_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_v_reg   <= 1'b0;
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            if (i_adv)
            begin
                i_v_reg <= item.valid;
            end
            if (a_adv)
            begin
                a_v_reg <= i_v_reg;
            end
            if (b_adv)
            begin
                b_v_reg <= a_v_reg;
            end
            if (res_free)
            begin
                res_v_reg <= b_v_reg;
            end
        end
    end

    // packed wheel order: front left, back left, middle left, front right,
    // back right, middle right
    always_comb
    begin
        in_item.action  = item.action;
        in_item.pos[0]  = item.pos_front_left;
        in_item.pos[1]  = item.pos_back_left;
        in_item.pos[2]  = item.pos_middle_left;
        in_item.pos[3]  = item.pos_front_right;
        in_item.pos[4]  = item.pos_back_right;
        in_item.pos[5]  = item.pos_middle_right;
        in_item.heading = item.heading;
    end

    always_ff @(posedge clk)
    begin
        if (i_adv && item.valid)
        begin
            i_reg <= in_item;
        end
        if (a_adv)
        begin
            a_reg <= front_c;
        end
        if (b_adv)
        begin
            b_reg <= prod_c;
        end
        if (res_free)
        begin
            res_reg <= res_c;
        end
    end

    dphh_front u_front (
        .item_in   (i_reg),
        .front_out (front_c)
    );

    dphh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .front_in (a_reg),
        .cfg      (cfg_reg),
        .prod_out (prod_c)
    );

    dphh_mix u_mix (
        .prod_in (b_reg),
        .cfg     (cfg_reg),
        .res_out (res_c)
    );

    assign result.valid            = res_v_reg;
    assign result.cmd_front_left   = res_reg.cmd[0];
    assign result.cmd_back_left    = res_reg.cmd[1];
    assign result.cmd_middle_left  = res_reg.cmd[2];
    assign result.cmd_front_right  = res_reg.cmd[3];
    assign result.cmd_back_right   = res_reg.cmd[4];
    assign result.cmd_middle_right = res_reg.cmd[5];
    assign result.finished         = res_reg.fin;

endmodule

`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for drive_pd_with_heading_hold: directed moves, integral wind-up
// runs, output stalls and random moves over many gain settings
// depends on dphh_pkg, dphh_in_if, dphh_out_if and the block itself
`default_nettype none

module tb;
    import dphh_pkg::*;

    localparam int     HEAD_MAX       = 57600;
    localparam longint POS_MAX        = (longint'(1) << (POSITION_BITS - 1)) - 1;
    localparam longint HEAD_SUM_MAX   = (longint'(1) << (HSUM_W - 1)) - 1;
    localparam longint HEAD_SUM_MIN   = -(longint'(1) << (HSUM_W - 1));
    localparam int     RANDOM_ITEMS   = 1040;
    localparam int     SAT_RUN        = 40;
    localparam int     SAT_RETURN     = 30;
    localparam int     PIPE_LATENCY   = 6;
    localparam int     HOLD_OFF       = 300;
    localparam int     WATCHDOG_LIMIT = 3000;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dphh_in_if  item_ch ();
    dphh_out_if res_ch ();

    drive_pd_with_heading_hold uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // register copy and controller history as the block should hold them
    cfg_t   cfg_shadow;
    longint drive_prev_err;
    longint head_sum;
    longint head_prev;
    bit     move_done;

    res_t   cmd_q [$];
    int     errors;
    int     items_sent;
    int     rand_items;
    int     results_seen;
    int     finished_seen;
    int     cfg_settings;
    int     burst_left;
    bit     no_idle;
    int     hold_cycles;
    bit     hold_active;
    int     idle_cycles;

    string cmd_name [WHEEL_COUNT] = '{"cmd_front_left", "cmd_back_left", "cmd_middle_left",
                                      "cmd_front_right", "cmd_back_right", "cmd_middle_right"};

    function automatic logic [CMD_W-1:0] clip_cmd(longint v);
        if (v > CMD_LIMIT)
            return CMD_W'(CMD_LIMIT);
        if (v < -CMD_LIMIT)
            return CMD_W'(-CMD_LIMIT);
        return CMD_W'(v);
    endfunction

    function automatic res_t predict_motor_cmds(item_t it);
        res_t   r;
        longint abs_sum, v, tgt, e, d, p, h, hd, t, turn;
        longint dkp, dkd, maxp, hkp, hki, hkd;
        r = '0;
        if (it.action == ACT_START) begin
            drive_prev_err = 0;
            head_sum = 0;
            head_prev = 0;
            move_done = 1'b0;
            return r;
        end
        abs_sum = 0;
        for (int i = 0; i < WHEEL_COUNT; i++) begin
            v = $signed(it.pos[i]);
            abs_sum += (v < 0) ? -v : v;
        end
        tgt = cfg_shadow.target_distance;
        // average strictly above the target, compared without dividing
        if (move_done || abs_sum > WHEEL_COUNT * tgt) begin
            move_done = 1'b1;
            r.fin = 1'b1;
            return r;
        end
        dkp  = cfg_shadow.distance_kp;
        dkd  = cfg_shadow.distance_kd;
        maxp = cfg_shadow.max_power;
        hkp  = cfg_shadow.heading_kp;
        hki  = cfg_shadow.heading_ki;
        hkd  = cfg_shadow.heading_kd;
        e = tgt - abs_sum / WHEEL_COUNT;
        d = e - drive_prev_err;
        drive_prev_err = e;
        p = (e * dkp + d * dkd) >>> GAIN_FRAC_BITS;
        if (p > maxp)
            p = maxp;
        h = $signed(it.heading);
        head_sum += h;
        if (head_sum > HEAD_SUM_MAX)
            head_sum = HEAD_SUM_MAX;
        if (head_sum < HEAD_SUM_MIN)
            head_sum = HEAD_SUM_MIN;
        hd = h - head_prev;
        head_prev = h;
        t = (h * hkp + head_sum * hki + hd * hkd) >>> GAIN_FRAC_BITS;
        turn = -t;
        if (cfg_shadow.reverse)
            p = -p;
        r.cmd[0] = clip_cmd(p + turn);
        r.cmd[1] = clip_cmd(p + turn);
        r.cmd[2] = clip_cmd(-p - turn);
        r.cmd[3] = clip_cmd(-p + turn);
        r.cmd[4] = clip_cmd(-p + turn);
        r.cmd[5] = clip_cmd(p - turn);
        r.fin = 1'b0;
        return r;
    endfunction

    function automatic int rand_heading();
        return int'($urandom_range(0, 2 * HEAD_MAX)) - HEAD_MAX;
    endfunction

    function automatic item_t start_item();
        item_t it;
        it.action = ACT_START;
        for (int i = 0; i < WHEEL_COUNT; i++)
            it.pos[i] = POSITION_BITS'($urandom);
        it.heading = HEAD_W'(rand_heading());
        return it;
    endfunction

    function automatic item_t uniform_tick(longint pos, int hdg);
        item_t it;
        it.action = ACT_TICK;
        for (int i = 0; i < WHEEL_COUNT; i++)
            it.pos[i] = POSITION_BITS'(pos);
        it.heading = HEAD_W'(hdg);
        return it;
    endfunction

    // wheels near a common travel, with jitter and random direction of count
    function automatic item_t make_tick(longint base, int hdg);
        item_t  it;
        longint v;
        it.action = ACT_TICK;
        for (int i = 0; i < WHEEL_COUNT; i++) begin
            v = base + longint'($urandom_range(0, 16)) - 8;
            if (v < 0)
                v = 0;
            if (v > POS_MAX)
                v = POS_MAX;
            if ($urandom_range(0, 3) == 0)
                v = -v;
            it.pos[i] = POSITION_BITS'(v);
        end
        it.heading = HEAD_W'(hdg);
        return it;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(cfg_idx_t idx);
        int typ;
        case (idx)
            REG_TARGET_DISTANCE: typ = 20000;
            REG_DISTANCE_KP:     typ = 768;
            REG_DISTANCE_KD:     typ = 1024;
            REG_MAX_POWER:       typ = CMD_LIMIT;
            REG_HEADING_KP:      typ = 2048;
            REG_HEADING_KI:      typ = 32;
            REG_HEADING_KD:      typ = 1024;
            default:             typ = 1;
        endcase
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, typ));
        endcase
    endfunction

    task automatic apply_config(input logic [CFG_DATA_W-1:0] vals [8]);
        cfg_idx_t idx;
        idx = idx.first();
        do begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            case (idx)
                REG_TARGET_DISTANCE: cfg_shadow.target_distance = vals[idx][TGT_W-1:0];
                REG_DISTANCE_KP:     cfg_shadow.distance_kp = vals[idx][GAIN_W-1:0];
                REG_DISTANCE_KD:     cfg_shadow.distance_kd = vals[idx][GAIN_W-1:0];
                REG_MAX_POWER:       cfg_shadow.max_power = vals[idx][MAXP_W-1:0];
                REG_HEADING_KP:      cfg_shadow.heading_kp = vals[idx][GAIN_W-1:0];
                REG_HEADING_KI:      cfg_shadow.heading_ki = vals[idx][GAIN_W-1:0];
                REG_HEADING_KD:      cfg_shadow.heading_kd = vals[idx][GAIN_W-1:0];
                REG_REVERSE:         cfg_shadow.reverse = vals[idx][0];
            endcase
            @(posedge clk);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_we <= 1'b0;
        cfg_settings++;
    endtask

    task automatic send_item(item_t it);
        int gap;
        if (!no_idle && burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid            <= 1'b1;
        item_ch.action           <= it.action;
        item_ch.pos_front_left   <= it.pos[0];
        item_ch.pos_back_left    <= it.pos[1];
        item_ch.pos_middle_left  <= it.pos[2];
        item_ch.pos_front_right  <= it.pos[3];
        item_ch.pos_back_right   <= it.pos[4];
        item_ch.pos_middle_right <= it.pos[5];
        item_ch.heading          <= it.heading;
        do
            @(posedge clk);
        while (!item_ch.ready);
        cmd_q.push_back(predict_motor_cmds(it));
        items_sent++;
        burst_left--;
    endtask

    // sender goes quiet until the pipeline has handed back everything
    task automatic wait_all_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (cmd_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        item_t it;
        send_item(start_item());
        send_item(uniform_tick(0, 100));
        send_item(uniform_tick(0, -HEAD_MAX));
        send_item(uniform_tick(0, HEAD_MAX));
        it = uniform_tick(0, 0);
        it.pos[4] = POSITION_BITS'(1);
        send_item(it);
        // finished stays set even once the wheels read zero again
        send_item(uniform_tick(0, 5));
        send_item(start_item());
        send_item(uniform_tick(0, 0));
        wait_all_results();
    endtask

    task automatic test_directed_extremes();
        logic [CFG_DATA_W-1:0] vals [8];
        item_t it;
        vals[REG_TARGET_DISTANCE] = '1;
        vals[REG_DISTANCE_KP]     = 256;
        vals[REG_DISTANCE_KD]     = 256;
        vals[REG_MAX_POWER]       = CMD_LIMIT;
        vals[REG_HEADING_KP]      = 1024;
        vals[REG_HEADING_KI]      = 0;
        vals[REG_HEADING_KD]      = 256;
        vals[REG_REVERSE]         = 0;
        apply_config(vals);
        send_item(start_item());
        send_item(uniform_tick(0, 0));
        // average exactly at the target is still driving
        it = uniform_tick(POS_MAX, HEAD_MAX);
        send_item(it);
        it.pos[2] = POSITION_BITS'(-(POS_MAX + 1));
        send_item(it);
        send_item(uniform_tick(0, 0));
        send_item(start_item());
        it = uniform_tick(500000, -HEAD_MAX);
        it.pos[1] = POSITION_BITS'(-500000);
        it.pos[3] = POSITION_BITS'(-500000);
        it.pos[5] = POSITION_BITS'(-500000);
        send_item(it);
        send_item(uniform_tick(400000, HEAD_MAX));
        wait_all_results();

        foreach (vals[i])
            vals[i] = '0;
        apply_config(vals);
        send_item(start_item());
        send_item(uniform_tick(0, HEAD_MAX));
        send_item(uniform_tick(-5, 0));
        wait_all_results();

        vals[REG_TARGET_DISTANCE] = 1000;
        vals[REG_DISTANCE_KP]     = 0;
        vals[REG_DISTANCE_KD]     = 16'hFFFF;
        vals[REG_MAX_POWER]       = CMD_LIMIT;
        vals[REG_HEADING_KP]      = 16'hFFFF;
        vals[REG_HEADING_KI]      = 16'hFFFF;
        vals[REG_HEADING_KD]      = 16'hFFFF;
        vals[REG_REVERSE]         = 1;
        apply_config(vals);
        send_item(start_item());
        send_item(uniform_tick(0, -1));
        // error shrinking fast drives the power negative, no lower clamp
        send_item(uniform_tick(900, 0));
        send_item(uniform_tick(-1000, 3));
        wait_all_results();
    endtask

    task automatic test_stalled_output();
        hold_cycles = HOLD_OFF;
        no_idle = 1'b1;
        wait (hold_active);
        send_item(start_item());
        for (int k = 0; k < 40; k++)
            send_item(make_tick(k * 20, k * 50 - 1000));
        no_idle = 1'b0;
        wait_all_results();
    endtask

    // constant heading with only the integral gain set winds the sum up and partly back,
    // once in each direction
    task automatic test_heading_saturation();
        logic [CFG_DATA_W-1:0] vals [8];
        foreach (vals[i])
            vals[i] = '0;
        vals[REG_MAX_POWER]  = CMD_LIMIT;
        vals[REG_HEADING_KI] = 1;
        apply_config(vals);
        no_idle = 1'b1;
        for (int s = 1; s >= -1; s -= 2) begin
            send_item(start_item());
            repeat (SAT_RUN) send_item(uniform_tick(0, s * HEAD_MAX));
            repeat (SAT_RETURN) send_item(uniform_tick(0, -s * HEAD_MAX));
        end
        no_idle = 1'b0;
        wait_all_results();
    endtask

    task automatic test_random_moves();
        logic [CFG_DATA_W-1:0] vals [8];
        cfg_idx_t idx;
        item_t    it;
        longint   base, step;
        int       phase, phase_items, len, hdg, r;
        phase = 0;
        while (rand_items < RANDOM_ITEMS) begin
            wait_all_results();
            idx = idx.first();
            do begin
                case (phase)
                    0:       vals[idx] = '1;
                    1:       vals[idx] = '0;
                    default: vals[idx] = pick_reg_value(idx);
                endcase
                idx = idx.next();
            end while (idx != idx.first());
            apply_config(vals);
            phase++;
            phase_items = 0;
            while (phase_items < 160 && rand_items < RANDOM_ITEMS) begin
                // now and then a move carries on from the previous history
                if ($urandom_range(0, 7) != 0) begin
                    send_item(start_item());
                    phase_items++;
                    rand_items++;
                end
                len = $urandom_range(3, 40);
                step = longint'(cfg_shadow.target_distance) / len + 1;
                base = 0;
                hdg = int'($urandom_range(0, 2000)) - 1000;
                for (int k = 0; k < len + 3; k++) begin
                    base += step * longint'($urandom_range(50, 150)) / 100;
                    hdg += int'($urandom_range(0, 600)) - 300;
                    if (hdg > HEAD_MAX)
                        hdg = HEAD_MAX;
                    if (hdg < -HEAD_MAX)
                        hdg = -HEAD_MAX;
                    r = $urandom_range(0, 29);
                    if (r < 3) begin
                        it.action = ($urandom_range(0, 3) == 0) ? ACT_START : ACT_TICK;
                        for (int i = 0; i < WHEEL_COUNT; i++)
                            it.pos[i] = POSITION_BITS'($urandom);
                        it.heading = HEAD_W'(rand_heading());
                    end else if (r == 3) begin
                        it = start_item();
                    end else begin
                        it = make_tick(base, hdg);
                    end
                    send_item(it);
                    phase_items++;
                    rand_items++;
                end
            end
        end
    endtask

    // receiver: changing stall profiles, plus a long hold-off on request
    initial begin : rx_side
        int profile;
        int span;
        int n;
        profile = 0;
        span = 0;
        n = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
                hold_active = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
                hold_active = 1'b0;
                n = 0;
            end else if (no_idle) begin
                res_ch.ready <= 1'b1;
            end else begin
                if (span == 0) begin
                    profile = $urandom_range(0, 3);
                    span = $urandom_range(16, 96);
                end
                span--;
                case (profile)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        if (n > 0) begin
                            res_ch.ready <= 1'b0;
                            n--;
                        end else begin
                            res_ch.ready <= 1'b1;
                            if ($urandom_range(0, 5) == 0)
                                n = $urandom_range(1, 20);
                        end
                    end
                endcase
            end
        end
    end

    // compare each result transfer with the oldest predicted command set
    always @(posedge clk) begin : check_cmds
        res_t got;
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.cmd[0] = res_ch.cmd_front_left;
            got.cmd[1] = res_ch.cmd_back_left;
            got.cmd[2] = res_ch.cmd_middle_left;
            got.cmd[3] = res_ch.cmd_front_right;
            got.cmd[4] = res_ch.cmd_back_right;
            got.cmd[5] = res_ch.cmd_middle_right;
            got.fin    = res_ch.finished;
            results_seen++;
            if (cmd_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected", $time);
            end else begin
                want = cmd_q.pop_front();
                if (want.fin)
                    finished_seen++;
                for (int i = 0; i < WHEEL_COUNT; i++) begin
                    if (got.cmd[i] !== want.cmd[i]) begin
                        errors++;
                        $display("%0t: %s expected %0d got %0d", $time, cmd_name[i],
                                 $signed(want.cmd[i]), $signed(got.cmd[i]));
                    end
                end
                if (got.fin !== want.fin) begin
                    errors++;
                    $display("%0t: finished expected %0b got %0b", $time, want.fin, got.fin);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, cmd_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        cfg_shadow.target_distance = '0;
        cfg_shadow.distance_kp     = 256;
        cfg_shadow.distance_kd     = '0;
        cfg_shadow.max_power       = CMD_LIMIT;
        cfg_shadow.heading_kp      = 1024;
        cfg_shadow.heading_ki      = '0;
        cfg_shadow.heading_kd      = 256;
        cfg_shadow.reverse         = 1'b0;
        drive_prev_err = 0;
        head_sum = 0;
        head_prev = 0;
        move_done = 1'b0;
        errors = 0;
        items_sent = 0;
        rand_items = 0;
        results_seen = 0;
        finished_seen = 0;
        cfg_settings = 0;
        burst_left = 0;
        no_idle = 1'b0;
        hold_cycles = 0;
        hold_active = 1'b0;
        idle_cycles = 0;

        rst_n                    <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_index                <= REG_TARGET_DISTANCE;
        cfg_data                 <= '0;
        item_ch.valid            <= 1'b0;
        item_ch.action           <= ACT_START;
        item_ch.pos_front_left   <= '0;
        item_ch.pos_back_left    <= '0;
        item_ch.pos_middle_left  <= '0;
        item_ch.pos_front_right  <= '0;
        item_ch.pos_back_right   <= '0;
        item_ch.pos_middle_right <= '0;
        item_ch.heading          <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_extremes();
        test_stalled_output();
        test_heading_saturation();
        test_random_moves();
        wait_all_results();

        $display("run covered %0d items and %0d results (%0d finished) over %0d gain settings",
                 items_sent, results_seen, finished_seen, cfg_settings);
        $display("including %0d random move items and %0d mismatches", rand_items, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
